// ===== rtl/dcbl_pkg.sv =====
// Package for the deepest-containing-box lookup core: widths, codes and types.
// No dependencies; used by dcbl_div and the lookup core.
`timescale 1ns / 1ps
package dcbl_pkg;
  localparam int CoordW = 32;
  localparam int IdW    = 32;
  localparam int SpanW  = 33;
  localparam int DepthW = 18;   // signed Q0.16 plus headroom for -1.0
  localparam int AreaW  = 66;
  localparam int DepthTol = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // entry as stored in the table memory
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] bottom;
  } entry_t;

  localparam int EntryW = $bits(entry_t);
endpackage

// ===== rtl/dcbl_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dcbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/dcbl_div.sv =====
// Restoring divider, one quotient bit per cycle: (dividend << 16) / span.
// Depends on dcbl_pkg.
`timescale 1ns / 1ps
module dcbl_div
  import dcbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SpanW-1:0] dividend,
  input  logic [SpanW-1:0] span,
  output logic             done,
  output logic [16:0]      quot
);
  // dividend <= span/2, so the quotient fits 16 bits plus one; 17 steps.
  // The high part (dividend >> 1) seeds the remainder, the low 17 bits of
  // dividend << 16 are shifted in one per step.
  logic [SpanW:0]   rem_r;
  logic [SpanW-1:0] span_r;
  logic [16:0]      num_r;
  logic [16:0]      q_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic [SpanW:0]   shifted;
  logic [SpanW+1:0] trial;

  assign shifted = {rem_r[SpanW-1:0], num_r[16]};
  assign trial   = {1'b0, shifted} - {2'b00, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd17;
        rem_r  <= {2'b00, dividend[SpanW-1:1]};
        num_r  <= {dividend[0], 16'd0};
        span_r <= span;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[15:0], 1'b0};
        if (!trial[SpanW+1]) begin
          rem_r <= trial[SpanW:0];
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[15:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quot = q_r;
endmodule

// ===== rtl/deepest_containing_box_lookup_core.sv =====
// Deepest-containing-box lookup core: table of rectangles, id and point queries.
// Depends on dcbl_pkg, dcbl_ram, dcbl_div.
// Write item: busy stays low, no result. Query: busy for the id pass (known_id
// nonzero only; a match skips the rest), then the geometric pass (two 17-step
// divides on the one shared divider per containing entry), then the done state,
// which strobes the result. One item at a time; the result strobe lands in the
// first idle cycle and the receiver cannot stall. Reset: entries_in_use cleared,
// control idle; table kept.
`timescale 1ns / 1ps
module deepest_containing_box_lookup_core
  import dcbl_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [7:0]        in_entry_index,
  input  logic [31:0]       in_entry_id,
  input  logic signed [31:0] in_edge_left,
  input  logic signed [31:0] in_edge_right,
  input  logic signed [31:0] in_edge_top,
  input  logic signed [31:0] in_edge_bottom,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic [31:0]       in_known_id,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_entries_in_use,
  output logic              out_valid,
  output logic              out_found,
  output logic [7:0]        out_chosen_index,
  output logic              out_matched_by_id
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ID_RD, S_ID_CHK, S_G_RD, S_G_WAIT, S_G_PREP, S_G_DX, S_G_DY,
    S_G_MUL, S_G_CMP, S_DONE
  } state_t;

  state_t state_r;
  logic [8:0]  eiu_r;
  logic [CW-1:0] n_r, idx_r;
  logic signed [CoordW-1:0] px_r, py_r;
  logic [IdW-1:0] kid_r;
  entry_t rd_q;
  logic   found_r, byid_r;
  logic [7:0] best_idx_r;
  logic signed [DepthW-1:0] best_depth_r;
  logic [63:0] best_area_r;
  logic [SpanW-1:0] spx_r, spy_r, dx_dist_r, dy_dist_r;
  logic [16:0] dx_r, dy_r;
  logic valid_ent_r;
  logic [63:0] area_r;
  logic div_start;
  logic [SpanW-1:0] div_dist, div_span;
  logic div_done;
  logic [16:0] div_q;
  logic [CW-1:0] n_clamp;
  logic wr_en;
  entry_t wr_data;

  // table memory
  assign wr_en = start && !busy && (in_operation == OP_WRITE) &&
                 (int'(in_entry_index) < TABLE_DEPTH);
  assign wr_data = '{in_entry_id, in_edge_left, in_edge_right, in_edge_top,
                     in_edge_bottom};

  dcbl_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .wr_en(wr_en), .wr_addr(AW'(in_entry_index)),
    .wr_data(wr_data), .rd_addr(idx_r[AW-1:0]), .rd_data(rd_q)
  );

  dcbl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dist),
    .span(div_span), .done(div_done), .quot(div_q)
  );

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign n_clamp = (int'(eiu_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(eiu_r);

  // per-entry geometry from the read data
  logic signed [SpanW-1:0] l, r, t, b, mnx, mxx, mny, mxy, pxe, pye;
  logic [SpanW-1:0] spx, spy, ax, bx, ay, by;
  logic in_box;
  always_comb begin
    l = SpanW'(signed'(rd_q.left));
    r = SpanW'(signed'(rd_q.right));
    t = SpanW'(signed'(rd_q.top));
    b = SpanW'(signed'(rd_q.bottom));
    pxe = SpanW'(px_r);
    pye = SpanW'(py_r);
    mnx = (l < r) ? l : r;
    mxx = (l < r) ? r : l;
    mny = (t < b) ? t : b;
    mxy = (t < b) ? b : t;
    spx = mxx - mnx;
    spy = mxy - mny;
    ax = pxe - mnx;
    bx = mxx - pxe;
    ay = pye - mny;
    by = mxy - pye;
    in_box = !(pxe < mnx || pxe > mxx || pye < mny || pye > mxy);
  end

  assign div_start = (state_r == S_G_PREP && valid_ent_r) ||
                     (state_r == S_G_DX && div_done);
  assign div_dist  = (state_r == S_G_PREP) ? dx_dist_r : dy_dist_r;
  assign div_span  = (state_r == S_G_PREP) ? spx_r : spy_r;

  // compare stage
  logic signed [DepthW-1:0] depth;
  logic take;
  always_comb begin
    depth = (dx_r < dy_r) ? DepthW'(dx_r) : DepthW'(dy_r);
    take = (depth > best_depth_r + DepthW'(DepthTol)) ||
           ((depth > best_depth_r - DepthW'(DepthTol)) && (area_r < best_area_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      eiu_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) eiu_r <= cfg_entries_in_use;
      case (state_r)
        S_IDLE: begin
          if (start && in_operation == OP_QUERY) begin
            px_r <= in_point_x;
            py_r <= in_point_y;
            kid_r <= in_known_id;
            n_r <= n_clamp;
            idx_r <= '0;
            found_r <= 1'b0;
            byid_r <= 1'b0;
            best_idx_r <= '0;
            best_depth_r <= -DepthW'(65536);
            best_area_r <= '1;
            state_r <= (in_known_id != '0) ? S_ID_RD : S_G_RD;
          end
        end
        // id pass: address issued, data next cycle
        S_ID_RD: begin
          state_r <= (idx_r < n_r) ? S_ID_CHK : S_G_RD;
          if (!(idx_r < n_r)) idx_r <= '0;
        end
        S_ID_CHK: begin
          if (rd_q.id == kid_r) begin
            found_r <= 1'b1;
            byid_r <= 1'b1;
            best_idx_r <= 8'(idx_r);
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_ID_RD;
          end
        end
        S_G_RD: state_r <= (idx_r < n_r) ? S_G_WAIT : S_DONE;
        S_G_WAIT: begin
          spx_r <= spx;
          spy_r <= spy;
          dx_dist_r <= (ax < bx) ? ax : bx;
          dy_dist_r <= (ay < by) ? ay : by;
          valid_ent_r <= (rd_q.id != '0) && (spx != '0) && (spy != '0) && in_box;
          state_r <= S_G_PREP;
        end
        S_G_PREP: begin
          if (valid_ent_r) state_r <= S_G_DX;
          else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_G_RD;
          end
        end
        S_G_DX: if (div_done) begin
          dx_r <= div_q;
          state_r <= S_G_DY;
        end
        S_G_DY: if (div_done) begin
          dy_r <= div_q;
          state_r <= S_G_MUL;
        end
        S_G_MUL: begin
          area_r <= spx_r[31:0] * spy_r[31:0] + ((spx_r[32] ? 64'(spy_r) : 64'd0) << 32)
                    + ((spy_r[32] ? 64'(spx_r[31:0]) : 64'd0) << 32);
          state_r <= S_G_CMP;
        end
        S_G_CMP: begin
          if (take) begin
            best_depth_r <= depth;
            best_area_r <= area_r;
            best_idx_r <= 8'(idx_r);
            found_r <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
          state_r <= S_G_RD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_found <= found_r;
          out_chosen_index <= found_r ? best_idx_r : 8'd0;
          out_matched_by_id <= byid_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // scan index never runs past the clamped count
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_CMP) |-> (idx_r < n_r)) else $error("scan index overrun");
  // results only leave through the done state
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE)) else $error("stray result");
  // id match always reports found
  a_byid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_matched_by_id) |-> out_found) else $error("id match not found");
endmodule
